### hdl/assert_macros.svh
// assertion macros used by the checker rtl
// expects signals clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SCC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/scc_pkg.sv
// shared types and constants of the source completeness checker
// no dependencies
package scc_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [1:0] NL_RUN_MAX = 2'd3;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_TERM  = 2'd1,
        CLS_OTHER = 2'd2
    } char_class_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       last;
    } item_t;

    typedef struct packed {
        logic complete;
        logic overflow;
    } verdict_t;

    // command broadcast to every stack cell
    typedef struct packed {
        logic push;
        logic pop;
        logic push_bit;
    } stack_cmd_t;

endpackage

### hdl/scc_cell.sv
// one entry of the shift stack: takes the upper neighbor on push,
// the lower neighbor on pop; depends on scc_pkg
module scc_cell (
    input  logic                clk,
    input  scc_pkg::stack_cmd_t cmd,
    input  logic                from_above,
    input  logic                from_below,
    output logic                value
);

    logic data_reg;
    logic data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.push)
        begin
            data_next = from_above;
        end
        else if (cmd.pop)
        begin
            data_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign value = data_reg;

endmodule

### hdl/scc_scan.sv
// scanner: string, comment and slash modes, stack count, classes and verdict
// drives the cell row through a stack command; depends on scc_pkg
`include "assert_macros.svh"

module scc_scan #(
    parameter int STACK_DEPTH = scc_pkg::STACK_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  scc_pkg::item_t       item,
    input  logic                 top_bit,
    output scc_pkg::stack_cmd_t  cmd,
    output scc_pkg::verdict_t    verdict
);

    localparam int CntW = $clog2(STACK_DEPTH + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(STACK_DEPTH);

    logic                 in_string_reg,  in_string_next;
    logic                 in_comment_reg, in_comment_next;
    logic                 slash_reg,      slash_next;
    logic [CntW-1:0]      count_reg,      count_next;
    scc_pkg::char_class_t class_reg,      class_next;
    logic                 mismatch_reg,   mismatch_next;
    logic [1:0]           nl_run_reg,     nl_run_next;
    logic                 overflow_reg,   overflow_next;

    logic       plain;
    logic       blank;
    logic       want;
    logic [7:0] c;

    assign c = item.ch;
    assign blank = (c == scc_pkg::CH_SPACE) || (c == scc_pkg::CH_TAB) ||
                   (c == scc_pkg::CH_LF) || (c == scc_pkg::CH_VT) ||
                   (c == scc_pkg::CH_FF) || (c == scc_pkg::CH_CR);
    assign want = (c == scc_pkg::CH_RBRACE);

    always_comb
    begin
        in_string_next  = in_string_reg;
        in_comment_next = in_comment_reg;
        slash_next      = slash_reg;
        count_next      = count_reg;
        class_next      = class_reg;
        mismatch_next   = mismatch_reg;
        nl_run_next     = nl_run_reg;
        overflow_next   = overflow_reg;
        cmd             = '0;
        plain           = 1'b0;

        if (take && item.has_char)
        begin
            if (c == scc_pkg::CH_LF)
            begin
                if (nl_run_reg != scc_pkg::NL_RUN_MAX)
                begin
                    nl_run_next = nl_run_reg + 2'd1;
                end
            end
            else
            begin
                nl_run_next = 2'd0;
            end

            if (mismatch_reg)
            begin
                plain = 1'b0;
            end
            else if (in_string_reg)
            begin
                if (c == scc_pkg::CH_QUOTE)
                begin
                    in_string_next = 1'b0;
                end
            end
            else if (in_comment_reg)
            begin
                if (c == scc_pkg::CH_LF)
                begin
                    in_comment_next = 1'b0;
                end
            end
            else if (slash_reg)
            begin
                slash_next = 1'b0;
                if (c == scc_pkg::CH_SLASH)
                begin
                    in_comment_next = 1'b1;
                end
                else
                begin
                    plain = 1'b1;
                end
            end
            else
            begin
                plain = 1'b1;
            end

            if (plain)
            begin
                if (c == scc_pkg::CH_SLASH)
                begin
                    slash_next = 1'b1;
                end
                else if ((c == scc_pkg::CH_RBRACE || c == scc_pkg::CH_RPAREN) &&
                         !(count_reg != '0 && top_bit == want))
                begin
                    // unmatched closer freezes everything but the newline count
                    mismatch_next = 1'b1;
                end
                else
                begin
                    if (c == scc_pkg::CH_QUOTE)
                    begin
                        in_string_next = 1'b1;
                    end
                    else if (c == scc_pkg::CH_LBRACE || c == scc_pkg::CH_LPAREN)
                    begin
                        if (count_reg < CntMax)
                        begin
                            cmd.push     = 1'b1;
                            cmd.push_bit = (c == scc_pkg::CH_LBRACE);
                            count_next   = count_reg + CntW'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    else if (c == scc_pkg::CH_RBRACE || c == scc_pkg::CH_RPAREN)
                    begin
                        cmd.pop    = 1'b1;
                        count_next = count_reg - CntW'(1);
                    end

                    if (!blank)
                    begin
                        if (c == scc_pkg::CH_NUL)
                        begin
                            class_next = scc_pkg::CLS_NONE;
                        end
                        else if (c == scc_pkg::CH_RBRACE || c == scc_pkg::CH_SEMI)
                        begin
                            class_next = scc_pkg::CLS_TERM;
                        end
                        else
                        begin
                            class_next = scc_pkg::CLS_OTHER;
                        end
                    end
                end
            end
        end

        verdict.complete = (nl_run_next == scc_pkg::NL_RUN_MAX) || mismatch_next ||
                           (!in_string_next && count_next == '0 &&
                            class_next != scc_pkg::CLS_OTHER);
        verdict.overflow = overflow_next;

        // end of source: everything returns to reset
        if (take && item.last)
        begin
            in_string_next  = 1'b0;
            in_comment_next = 1'b0;
            slash_next      = 1'b0;
            count_next      = '0;
            class_next      = scc_pkg::CLS_NONE;
            mismatch_next   = 1'b0;
            nl_run_next     = 2'd0;
            overflow_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_string_reg  <= 1'b0;
            in_comment_reg <= 1'b0;
            slash_reg      <= 1'b0;
            count_reg      <= '0;
            class_reg      <= scc_pkg::CLS_NONE;
            mismatch_reg   <= 1'b0;
            nl_run_reg     <= 2'd0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            in_string_reg  <= in_string_next;
            in_comment_reg <= in_comment_next;
            slash_reg      <= slash_next;
            count_reg      <= count_next;
            class_reg      <= class_next;
            mismatch_reg   <= mismatch_next;
            nl_run_reg     <= nl_run_next;
            overflow_reg   <= overflow_next;
        end
    end

    `SCC_ASSERT_ALWAYS(a_count_bound, count_reg <= CntMax, "stack count above depth")
    `SCC_ASSERT_ALWAYS(a_push_pop_excl, !(cmd.push && cmd.pop), "push and pop together")
    `SCC_ASSERT_ALWAYS(a_modes_excl, !(in_string_reg && in_comment_reg),
                       "string and comment both open")
    `SCC_ASSERT_NEXT(a_clear_after_last, take && item.last,
                     count_reg == '0 && !mismatch_reg && !overflow_reg && !slash_reg,
                     "state not cleared after end of source")

endmodule

### hdl/source_completeness_checker.sv
// top level of the source completeness checker
// uses scc_pkg, scc_scan and a row of scc_cell entries
//
// Usage:
//   item channel (item_valid / item_ready / item) carries one source byte
//   per transaction with has_char and last flags. verdict channel
//   (verdict_valid / verdict_ready / verdict) carries complete and overflow,
//   one transaction for each item marked last, none for other items.
//   Throughput: one item per cycle unless stalled. The byte is scanned and the
//   bracket stack updated in the cycle of acceptance; the stack is a row of
//   STACK_DEPTH one-bit cells that shift together on every push or pop.
//   Latency: the verdict appears in the output register on the cycle after
//   the last item is accepted.
//   Stall: while a verdict waits and verdict_ready is low, item_ready is low;
//   a verdict taken in the same cycle frees the register for the next one.
//   Reset: asynchronous, active low; clears all modes, counts and flags and
//   the output valid flag. Stack cells hold no reset value and are only read
//   below the current count. After each verdict the state returns to reset.
module source_completeness_checker #(
    parameter int STACK_DEPTH = scc_pkg::STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  scc_pkg::item_t    item,
    output logic              verdict_valid,
    input  logic              verdict_ready,
    output scc_pkg::verdict_t verdict
);

    logic                take;
    scc_pkg::stack_cmd_t cmd;
    scc_pkg::verdict_t   scan_verdict;
    logic [STACK_DEPTH-1:0] cell_q;

    logic              valid_reg, valid_next;
    scc_pkg::verdict_t data_reg,  data_next;

    assign item_ready = !valid_reg || verdict_ready;
    assign take       = item_valid && item_ready;

    scc_scan #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .item    (item),
        .top_bit (cell_q[0]),
        .cmd     (cmd),
        .verdict (scan_verdict)
    );

    // cell 0 is the top of the stack
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic above;
        logic below;
        if (i == 0)
        begin : g_top
            assign above = cmd.push_bit;
        end
        else
        begin : g_mid
            assign above = cell_q[i-1];
        end
        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign below = 1'b0;
        end
        else
        begin : g_inner
            assign below = cell_q[i+1];
        end
        scc_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .from_above (above),
            .from_below (below),
            .value      (cell_q[i])
        );
    end

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (verdict_valid && verdict_ready)
        begin
            valid_next = 1'b0;
        end
        if (take && item.last)
        begin
            valid_next = 1'b1;
            data_next  = scan_verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign verdict_valid = valid_reg;
    assign verdict       = data_reg;

endmodule
